FILE: hw/rtl/markdown_block_line_classifier_defines.svh
// Assertion macros for the markdown block line classifier.
`ifndef MARKDOWN_BLOCK_LINE_CLASSIFIER_DEFINES_SVH
`define MARKDOWN_BLOCK_LINE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

`define MBC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mbc assertion failed");

`define MBC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mbc assertion failed");

`define MBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mbc assertion failed");

`else

`define MBC_ASSERT(lbl, clk, rstn, prop)
`define MBC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define MBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hw/rtl/mbc_pkg.sv
// Shared types, constants and helpers of the markdown block line classifier.
package mbc_pkg;

  localparam int OffsetBits = 32;
  localparam int OutW       = 32;
  localparam int OutqDepth  = 4;
  localparam int OutqPtrW   = $clog2(OutqDepth);
  localparam int OutqCntW   = $clog2(OutqDepth + 1);

  typedef logic [OffsetBits-1:0] ofs_t;

  // Token kinds
  localparam logic [2:0] KindPara  = 3'd0;
  localparam logic [2:0] KindHead  = 3'd1;
  localparam logic [2:0] KindCode  = 3'd2;
  localparam logic [2:0] KindRule  = 3'd3;
  localparam logic [2:0] KindQuote = 3'd4;
  localparam logic [2:0] KindList  = 3'd5;
  localparam logic [2:0] KindEnd   = 3'd6;

  // Scan phases
  localparam logic [3:0] PhLead   = 4'd0;
  localparam logic [3:0] PhBody   = 4'd1;
  localparam logic [3:0] PhHrun   = 4'd2;
  localparam logic [3:0] PhHsp    = 4'd3;
  localparam logic [3:0] PhTick   = 4'd4;
  localparam logic [3:0] PhRule1  = 4'd5;
  localparam logic [3:0] PhRrun   = 4'd6;
  localparam logic [3:0] PhRtail  = 4'd7;
  localparam logic [3:0] PhQuote  = 4'd8;
  localparam logic [3:0] PhDigit  = 4'd9;
  localparam logic [3:0] PhClosed = 4'd10;

  // Characters
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChTick  = 8'h60;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Rule character codes
  localparam logic [1:0] RcNone  = 2'd0;
  localparam logic [1:0] RcDash  = 2'd1;
  localparam logic [1:0] RcStar  = 2'd2;
  localparam logic [1:0] RcUnder = 2'd3;

  localparam logic [2:0] MaxHeadLevel = 3'd6;
  localparam logic [2:0] FenceTicks   = 3'd3;
  localparam logic [2:0] RuleMarks    = 3'd3;

  typedef struct packed {
    logic [2:0]      kind;
    logic [OutW-1:0] line_ofs;
    logic [OutW-1:0] line_len;
    logic [OutW-1:0] cont_ofs;
    logic [OutW-1:0] cont_len;
    logic [2:0]      level;
    logic            run_end;
  } mbc_res_t;

  // Results produced by one input byte: count and up to two entries
  typedef struct packed {
    logic [1:0] n;
    mbc_res_t   r0;
    mbc_res_t   r1;
  } mbc_wr_t;

  function automatic logic [1:0] rule_code(input logic [7:0] b);
    logic [1:0] rc;
    rc = RcNone;
    if (b == ChDash) rc = RcDash;
    else if (b == ChStar) rc = RcStar;
    else if (b == ChUnder) rc = RcUnder;
    return rc;
  endfunction

endpackage

FILE: hw/rtl/mbc_core.sv
// Line scanner: per-byte state update and line/end result generation.
`include "markdown_block_line_classifier_defines.svh"

module mbc_core
  import mbc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] data_i,
  input  logic       fin_i,
  output mbc_wr_t    wr_o
);

  ofs_t       pos_q, pos_d;
  ofs_t       lstart_q, lstart_d;
  logic       fence_q, fence_d;
  logic [3:0] phase_q, phase_d;
  logic [2:0] kind_q, kind_d;
  ofs_t       cb_q, cb_d;
  logic [2:0] mc_q, mc_d;
  logic [1:0] rc_q, rc_d;

  logic       nl, fin_line;
  ofs_t       p, nxt, cend, f_cb, f_cl;
  logic [3:0] a_phase;
  logic [2:0] a_kind, a_mc, mc_inc, f_kind, f_lvl;
  ofs_t       a_cb;
  logic [1:0] a_rc, rc_in;
  logic       a_fence, f_empty;

  // Per-byte scan
  always_comb begin
    nl      = data_i == ChNl;
    p       = pos_q;
    nxt     = pos_q + ofs_t'(1);
    rc_in   = rule_code(data_i);
    mc_inc  = mc_q + 3'd1;
    a_phase = phase_q;
    a_kind  = kind_q;
    a_mc    = mc_q;
    a_cb    = cb_q;
    a_rc    = rc_q;
    a_fence = fence_q;
    if (!nl) begin
      unique case (phase_q)
        PhLead: begin
          if (data_i != ChSpace && data_i != ChTab) begin
            a_cb = p;
            a_mc = 3'd0;
            priority if (fence_q) begin
              if (data_i == ChTick) begin
                a_phase = PhTick;
                a_mc    = 3'd1;
              end else begin
                a_phase = PhBody;
                a_kind  = KindCode;
              end
            end else if (data_i == ChHash) begin
              a_phase = PhHrun;
              a_mc    = 3'd1;
            end else if (data_i == ChTick) begin
              a_phase = PhTick;
              a_mc    = 3'd1;
            end else if (rc_in != RcNone) begin
              a_phase = PhRule1;
              a_mc    = 3'd1;
              a_rc    = rc_in;
            end else if (data_i == ChGt) begin
              a_phase = PhQuote;
              a_cb    = nxt;
            end else if (data_i >= ChZero && data_i <= ChNine) begin
              a_phase = PhDigit;
            end else begin
              a_phase = PhBody;
              a_kind  = KindPara;
            end
          end
        end
        PhHrun: begin
          priority if (data_i == ChHash) begin
            if (mc_q < MaxHeadLevel) a_mc = mc_inc;
          end else if (data_i == ChSpace) begin
            a_phase = PhHsp;
          end else begin
            a_cb    = p;
            a_phase = PhBody;
            a_kind  = KindHead;
          end
        end
        PhHsp: begin
          if (data_i != ChSpace) begin
            a_cb    = p;
            a_phase = PhBody;
            a_kind  = KindHead;
          end
        end
        PhTick: begin
          if (data_i == ChTick) begin
            a_mc = mc_inc;
            if (mc_inc >= FenceTicks) begin
              if (fence_q) begin
                a_fence = 1'b0;
                a_phase = PhClosed;
                a_mc    = 3'd0;
              end else begin
                a_fence = 1'b1;
                a_cb    = nxt;
                a_phase = PhBody;
                a_kind  = KindCode;
                a_mc    = 3'd0;
              end
            end
          end else begin
            a_phase = PhBody;
            a_kind  = fence_q ? KindCode : KindPara;
            a_mc    = 3'd0;
          end
        end
        PhRule1: begin
          priority if (rc_in == rc_q && rc_q != RcNone) begin
            a_mc = mc_inc;
            if (mc_inc >= RuleMarks) a_phase = PhRrun;
          end else if (mc_q == 3'd1 && data_i == ChSpace && rc_q != RcUnder) begin
            a_cb    = nxt;
            a_phase = PhBody;
            a_kind  = KindList;
            a_mc    = 3'd0;
          end else begin
            a_phase = PhBody;
            a_kind  = KindPara;
            a_mc    = 3'd0;
          end
        end
        PhRrun: begin
          if (rc_in != rc_q) begin
            if (data_i == ChSpace) begin
              a_phase = PhRtail;
            end else begin
              a_phase = PhBody;
              a_kind  = KindPara;
              a_mc    = 3'd0;
            end
          end
        end
        PhRtail: begin
          if (data_i != ChSpace) begin
            a_phase = PhBody;
            a_kind  = KindPara;
            a_mc    = 3'd0;
          end
        end
        PhQuote: begin
          if (data_i == ChSpace) a_cb = nxt;
          a_phase = PhBody;
          a_kind  = KindQuote;
          a_mc    = 3'd0;
        end
        PhDigit: begin
          a_phase = PhBody;
          if (data_i == ChDot) begin
            a_cb   = nxt;
            a_kind = KindList;
            a_mc   = 3'd1;
          end else begin
            a_kind = KindPara;
            a_mc   = 3'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Line result
  always_comb begin
    cend    = nl ? p : nxt;
    f_cb    = a_cb;
    f_lvl   = 3'd0;
    f_empty = 1'b0;
    unique case (a_phase)
      PhLead: begin
        f_kind = a_fence ? KindCode : KindPara;
        f_cb   = cend;
      end
      PhBody: begin
        f_kind = a_kind;
        f_lvl  = a_mc;
      end
      PhHrun, PhHsp: begin
        f_kind = KindHead;
        f_cb   = cend;
        f_lvl  = a_mc;
      end
      PhTick:          f_kind = a_fence ? KindCode : KindPara;
      PhRrun, PhRtail: begin
        f_kind  = KindRule;
        f_empty = 1'b1;
      end
      PhQuote:         f_kind = KindQuote;
      PhClosed: begin
        f_kind  = KindCode;
        f_empty = 1'b1;
      end
      default:         f_kind = KindPara;
    endcase
    if (f_empty) begin
      f_cb = '0;
      f_cl = '0;
    end else begin
      f_cl = cend - f_cb;
    end
    fin_line = nl | fin_i;

    wr_o.n           = !acc_i ? 2'd0 : (fin_i ? 2'd2 : (nl ? 2'd1 : 2'd0));
    wr_o.r0.kind     = f_kind;
    wr_o.r0.line_ofs = OutW'(lstart_q);
    wr_o.r0.line_len = OutW'(ofs_t'(nxt - lstart_q));
    wr_o.r0.cont_ofs = OutW'(f_cb);
    wr_o.r0.cont_len = OutW'(f_cl);
    wr_o.r0.level    = f_lvl;
    wr_o.r0.run_end  = !fin_i;
    wr_o.r1.kind     = KindEnd;
    wr_o.r1.line_ofs = OutW'(nxt);
    wr_o.r1.line_len = '0;
    wr_o.r1.cont_ofs = '0;
    wr_o.r1.cont_len = '0;
    wr_o.r1.level    = 3'd0;
    wr_o.r1.run_end  = 1'b1;
  end

  // Next state
  always_comb begin
    pos_d    = pos_q;
    lstart_d = lstart_q;
    fence_d  = fence_q;
    phase_d  = phase_q;
    kind_d   = kind_q;
    cb_d     = cb_q;
    mc_d     = mc_q;
    rc_d     = rc_q;
    if (acc_i) begin
      pos_d = fin_i ? '0 : nxt;
      if (fin_line) begin
        lstart_d = fin_i ? '0 : nxt;
        fence_d  = fin_i ? 1'b0 : a_fence;
        phase_d  = PhLead;
        kind_d   = KindPara;
        cb_d     = '0;
        mc_d     = 3'd0;
        rc_d     = RcNone;
      end else begin
        fence_d = a_fence;
        phase_d = a_phase;
        kind_d  = a_kind;
        cb_d    = a_cb;
        mc_d    = a_mc;
        rc_d    = a_rc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      lstart_q <= '0;
      fence_q  <= 1'b0;
      phase_q  <= PhLead;
      kind_q   <= KindPara;
      cb_q     <= '0;
      mc_q     <= 3'd0;
      rc_q     <= RcNone;
    end else begin
      pos_q    <= pos_d;
      lstart_q <= lstart_d;
      fence_q  <= fence_d;
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      cb_q     <= cb_d;
      mc_q     <= mc_d;
      rc_q     <= rc_d;
    end
  end

  `MBC_ASSERT_NEXT(a_fin_restart, clk_i, rst_ni, acc_i && fin_i,
                   pos_q == '0 && lstart_q == '0 && !fence_q)
  `MBC_ASSERT_NEXT(a_line_restart, clk_i, rst_ni, acc_i && fin_line,
                   phase_q == PhLead && mc_q == 3'd0)
  `MBC_ASSERT_SAME(a_line_start_behind, clk_i, rst_ni, phase_q != PhLead,
                   cb_q != lstart_q || pos_q != lstart_q)

endmodule

FILE: hw/rtl/mbc_outq.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while popped.
`include "markdown_block_line_classifier_defines.svh"

module mbc_outq
  import mbc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mbc_wr_t  wr_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output mbc_res_t res_o
);

  mbc_res_t              mem [OutqDepth];
  logic [OutqPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OutqPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OutqCntW-1:0]   cnt_q, cnt_d;
  logic                  do_pop;
  logic [OutqPtrW-1:0]   wr_ptr_1;

  always_comb begin
    do_pop   = pop_i && cnt_q != '0;
    wr_ptr_1 = wr_ptr_q + OutqPtrW'(1);
    wr_ptr_d = wr_ptr_q + OutqPtrW'(wr_i.n);
    rd_ptr_d = do_pop ? rd_ptr_q + OutqPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OutqCntW'(wr_i.n) - OutqCntW'(do_pop);
    valid_o  = cnt_q != '0;
    full_o   = cnt_q > OutqCntW'(OutqDepth - 2);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.n != 2'd0) mem[wr_ptr_q] <= wr_i.r0;
    if (wr_i.n == 2'd2) mem[wr_ptr_1] <= wr_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign res_o = mem[rd_ptr_q];

  `MBC_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= OutqCntW'(OutqDepth))
  `MBC_ASSERT_SAME(a_no_overflow, clk_i, rst_ni, wr_i.n != 2'd0,
                   cnt_q <= OutqCntW'(OutqDepth - 2))
  `MBC_ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, do_pop && wr_i.n == 2'd0,
                   cnt_q == $past(cnt_q) - OutqCntW'(1))

endmodule

FILE: hw/rtl/markdown_block_line_classifier.sv
// Markdown block line classifier: top level.
// Items enter the registered result queue when their byte is taken, an end item last.
// One byte per cycle unless stalled; a final byte yields two items, popped one per cycle.
// Input stalls only while the four-entry result queue holds more than two items.
// Reset (rst_ni low, asynchronous) clears scan state, offsets and the result queue.
module markdown_block_line_classifier
  import mbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_kind_o,
  output logic [31:0] line_offset_o,
  output logic [31:0] line_length_o,
  output logic [31:0] content_offset_o,
  output logic [31:0] content_length_o,
  output logic [2:0]  level_o,
  output logic        run_end_o
);

  mbc_wr_t  wr;
  mbc_res_t res;
  logic     full;
  logic     acc;

  assign acc        = in_valid_i && !full;
  assign in_stall_o = full;

  mbc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .data_i (data_byte_i),
    .fin_i  (final_byte_i),
    .wr_o   (wr)
  );

  mbc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .full_o  (full),
    .valid_o (out_valid_o),
    .pop_i   (!out_stall_i),
    .res_o   (res)
  );

  assign token_kind_o     = res.kind;
  assign line_offset_o    = res.line_ofs;
  assign line_length_o    = res.line_len;
  assign content_offset_o = res.cont_ofs;
  assign content_length_o = res.cont_len;
  assign level_o          = res.level;
  assign run_end_o        = res.run_end;

endmodule

FILE: tb/sv/tb_markdown_block_line_classifier.sv
// Self-checking testbench for the markdown block line classifier: directed table, random documents.
`timescale 1ns / 100ps

module tb_markdown_block_line_classifier;
  import mbc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    mbc_res_t   t0;
    mbc_res_t   t1;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        final_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  token_kind_o;
  logic [31:0] line_offset_o;
  logic [31:0] line_length_o;
  logic [31:0] content_offset_o;
  logic [31:0] content_length_o;
  logic [2:0]  level_o;
  logic        run_end_o;

  markdown_block_line_classifier uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .final_byte_i     (final_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .token_kind_o     (token_kind_o),
    .line_offset_o    (line_offset_o),
    .line_length_o    (line_length_o),
    .content_offset_o (content_offset_o),
    .content_length_o (content_length_o),
    .level_o          (level_o),
    .run_end_o        (run_end_o)
  );

  mbc_res_t    pending_tokens[$];
  stim_row_t   directed_rows[$];
  logic [7:0]  doc[$];
  int          mismatches;
  int          send_gap_pct;
  int          stall_pct;
  int          hold_request;

  // Line classifier state
  logic [31:0] scan_pos;
  logic [31:0] line_base;
  logic [31:0] text_begin;
  logic        in_fence;
  logic [3:0]  phase;
  logic [2:0]  line_kind;
  logic [2:0]  mark_cnt;
  logic [1:0]  rule_mark;

  function automatic mbc_res_t tok(logic [2:0] kind, logic [31:0] lo, logic [31:0] ll,
                                   logic [31:0] co, logic [31:0] cl, logic [2:0] lvl,
                                   logic re);
    mbc_res_t r;
    r.kind     = kind;
    r.line_ofs = lo;
    r.line_len = ll;
    r.cont_ofs = co;
    r.cont_len = cl;
    r.level    = lvl;
    r.run_end  = re;
    return r;
  endfunction

  function automatic void clear_model();
    scan_pos   = '0;
    line_base  = '0;
    text_begin = '0;
    in_fence   = 1'b0;
    phase      = PhLead;
    line_kind  = KindPara;
    mark_cnt   = '0;
    rule_mark  = RcNone;
  endfunction

  function automatic logic [1:0] mark_of(logic [7:0] b);
    if (b == ChDash) return RcDash;
    if (b == ChStar) return RcStar;
    if (b == ChUnder) return RcUnder;
    return RcNone;
  endfunction

  function automatic void go_body(logic [2:0] kind, logic [2:0] lvl);
    phase     = PhBody;
    line_kind = kind;
    mark_cnt  = lvl;
  endfunction

  function automatic void step_scan(logic [7:0] b, logic [31:0] p);
    logic [31:0] nxt;
    nxt = p + 32'd1;
    case (phase)
      PhLead: begin
        if (b != ChSpace && b != ChTab) begin
          text_begin = p;
          mark_cnt   = '0;
          if (in_fence) begin
            if (b == ChTick) begin
              phase    = PhTick;
              mark_cnt = 3'd1;
            end else go_body(KindCode, 3'd0);
          end else if (b == ChHash) begin
            phase    = PhHrun;
            mark_cnt = 3'd1;
          end else if (b == ChTick) begin
            phase    = PhTick;
            mark_cnt = 3'd1;
          end else if (mark_of(b) != RcNone) begin
            phase     = PhRule1;
            mark_cnt  = 3'd1;
            rule_mark = mark_of(b);
          end else if (b == ChGt) begin
            phase      = PhQuote;
            text_begin = nxt;
          end else if (b >= ChZero && b <= ChNine) begin
            phase = PhDigit;
          end else go_body(KindPara, 3'd0);
        end
      end
      PhHrun: begin
        if (b == ChHash) begin
          if (mark_cnt < MaxHeadLevel) mark_cnt = mark_cnt + 3'd1;
        end else if (b == ChSpace) begin
          phase = PhHsp;
        end else begin
          text_begin = p;
          go_body(KindHead, mark_cnt);
        end
      end
      PhHsp: begin
        if (b != ChSpace) begin
          text_begin = p;
          go_body(KindHead, mark_cnt);
        end
      end
      PhTick: begin
        if (b == ChTick) begin
          mark_cnt = mark_cnt + 3'd1;
          if (mark_cnt >= FenceTicks) begin
            if (in_fence) begin
              in_fence = 1'b0;
              phase    = PhClosed;
              mark_cnt = '0;
            end else begin
              in_fence   = 1'b1;
              text_begin = nxt;
              go_body(KindCode, 3'd0);
            end
          end
        end else go_body(in_fence ? KindCode : KindPara, 3'd0);
      end
      PhRule1: begin
        if (mark_of(b) == rule_mark && rule_mark != RcNone) begin
          mark_cnt = mark_cnt + 3'd1;
          if (mark_cnt >= RuleMarks) phase = PhRrun;
        end else if (mark_cnt == 3'd1 && b == ChSpace && rule_mark != RcUnder) begin
          text_begin = nxt;
          go_body(KindList, 3'd0);
        end else go_body(KindPara, 3'd0);
      end
      PhRrun: begin
        if (mark_of(b) != rule_mark) begin
          if (b == ChSpace) phase = PhRtail;
          else go_body(KindPara, 3'd0);
        end
      end
      PhRtail: begin
        if (b != ChSpace) go_body(KindPara, 3'd0);
      end
      PhQuote: begin
        if (b == ChSpace) text_begin = nxt;
        go_body(KindQuote, 3'd0);
      end
      PhDigit: begin
        if (b == ChDot) begin
          text_begin = nxt;
          go_body(KindList, 3'd1);
        end else go_body(KindPara, 3'd0);
      end
      default: ;
    endcase
  endfunction

  function automatic mbc_res_t close_line(logic [31:0] p, logic [31:0] cend, logic re);
    mbc_res_t    r;
    logic [2:0]  k;
    logic [2:0]  lvl;
    logic [31:0] cb;
    logic [31:0] cl;
    logic        blank;
    k     = KindPara;
    lvl   = '0;
    cb    = text_begin;
    blank = 1'b0;
    case (phase)
      PhLead: begin
        k  = in_fence ? KindCode : KindPara;
        cb = cend;
      end
      PhBody: begin
        k   = line_kind;
        lvl = mark_cnt;
      end
      PhHrun, PhHsp: begin
        k   = KindHead;
        cb  = cend;
        lvl = mark_cnt;
      end
      PhTick: k = in_fence ? KindCode : KindPara;
      PhRrun, PhRtail: begin
        k     = KindRule;
        blank = 1'b1;
      end
      PhQuote: k = KindQuote;
      PhClosed: begin
        k     = KindCode;
        blank = 1'b1;
      end
      default: k = KindPara;
    endcase
    if (blank) begin
      cb = '0;
      cl = '0;
    end else cl = cend - cb;
    r          = tok(k, line_base, p + 32'd1 - line_base, cb, cl, lvl, re);
    line_base  = p + 32'd1;
    phase      = PhLead;
    line_kind  = KindPara;
    text_begin = '0;
    mark_cnt   = '0;
    rule_mark  = RcNone;
    return r;
  endfunction

  function automatic void classify_byte(input logic [7:0] b, input logic fin, output int n,
                                        output mbc_res_t r0, output mbc_res_t r1);
    logic [31:0] p;
    p        = scan_pos;
    scan_pos = p + 32'd1;
    n        = 0;
    r0       = '0;
    r1       = '0;
    if (b == ChNl) begin
      r0 = close_line(p, p, !fin);
      n  = 1;
    end else begin
      step_scan(b, p);
      if (fin) begin
        r0 = close_line(p, p + 32'd1, 1'b0);
        n  = 1;
      end
    end
    if (fin) begin
      r1 = tok(KindEnd, p + 32'd1, '0, '0, '0, 3'd0, 1'b1);
      n  = 2;
      clear_model();
    end
  endfunction

  function automatic void put_row(logic [7:0] d, logic lst, logic ty, mbc_res_t a,
                                  mbc_res_t z);
    stim_row_t row;
    row.data  = d;
    row.last  = lst;
    row.typed = ty;
    row.t0    = a;
    row.t1    = z;
    directed_rows.push_back(row);
  endfunction

  function automatic void put_run(logic [7:0] d, int cnt);
    repeat (cnt) put_row(d, 1'b0, 1'b0, '0, '0);
  endfunction

  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 15))
      0: return ChHash;
      1: return ChTick;
      2: return ChGt;
      3: return ChDash;
      4: return ChStar;
      5: return ChUnder;
      6: return ChDot;
      7: return ChSpace;
      8: return ChTab;
      9: return ChZero + 8'($urandom_range(0, 9));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic void text_run(int lo, int hi);
    repeat ($urandom_range(lo, hi)) doc.push_back(text_char());
  endfunction

  function automatic logic [7:0] any_mark();
    case ($urandom_range(0, 2))
      0: return ChDash;
      1: return ChStar;
      default: return ChUnder;
    endcase
  endfunction

  // One line of a random document, mostly well formed
  function automatic void gen_line(logic last_line);
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) doc.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
    case ($urandom_range(0, 11))
      0, 1: text_run(1, 6);
      2: begin
        repeat ($urandom_range(1, 8)) doc.push_back(ChHash);
        repeat ($urandom_range(0, 2)) doc.push_back(ChSpace);
        text_run(0, 4);
      end
      3: begin
        repeat ($urandom_range(2, 4)) doc.push_back(ChTick);
        text_run(0, 3);
      end
      4: begin
        c = any_mark();
        repeat ($urandom_range(1, 5)) doc.push_back(c);
        if ($urandom_range(0, 1) != 0) repeat ($urandom_range(1, 2)) doc.push_back(ChSpace);
        if ($urandom_range(0, 3) == 0) text_run(1, 2);
      end
      5: begin
        doc.push_back(ChGt);
        if ($urandom_range(0, 1) != 0) doc.push_back(ChSpace);
        text_run(0, 4);
      end
      6: begin
        doc.push_back(any_mark());
        if ($urandom_range(0, 3) != 0) doc.push_back(ChSpace);
        text_run(0, 4);
      end
      7: begin
        doc.push_back(ChZero + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 3) != 0) doc.push_back(ChDot);
        text_run(0, 4);
      end
      8: repeat ($urandom_range(0, 3)) doc.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
      9: repeat ($urandom_range(1, 5)) doc.push_back(8'($urandom_range(0, 255)));
      default: text_run(0, 5);
    endcase
    if (!last_line || $urandom_range(0, 1) != 0) doc.push_back(ChNl);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input mbc_res_t t0, input mbc_res_t t1);
    int       n;
    mbc_res_t r0;
    mbc_res_t r1;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_gap_pct);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    classify_byte(b, fin, n, r0, r1);
    if (typed) begin
      r0 = t0;
      r1 = t1;
    end
    if (n > 0) pending_tokens.push_back(r0);
    if (n > 1) pending_tokens.push_back(r1);
  endtask

  task automatic run_docs(input int item_goal);
    int sent;
    int nl;
    sent = 0;
    while (sent < item_goal) begin
      doc.delete();
      nl = $urandom_range(1, 6);
      for (int j = 0; j < nl; j++) gen_line(j == nl - 1);
      if (doc.size() == 0) doc.push_back(text_char());
      foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1, 1'b0, '0, '0);
      sent += doc.size();
    end
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    mbc_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: expected none, actual kind %0d offset %0d", $time,
                 token_kind_o, line_offset_o);
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 32'(want.kind), 32'(token_kind_o));
        check_field("line_offset", want.line_ofs, line_offset_o);
        check_field("line_length", want.line_len, line_length_o);
        check_field("content_offset", want.cont_ofs, content_offset_o);
        check_field("content_length", want.cont_len, content_length_o);
        check_field("level", 32'(want.level), 32'(level_o));
        check_field("run_end", 32'(want.run_end), 32'(run_end_o));
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int hold;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        hold         = hold_request;
        hold_request = 0;
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(posedge clk_i);
      end else out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #3_200_000;
    $display("tb_markdown_block_line_classifier: FAIL");
    $finish;
  end

  initial begin
    int drain;
    mismatches   = 0;
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_request = 0;
    clear_model();
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    data_byte_i  <= '0;
    final_byte_i <= 1'b0;

    // empty line, saturated heading with no text, rule, fence open and close at
    // document end, whitespace-only final line, extreme byte values
    put_row(ChNl, 1'b0, 1'b1, tok(KindPara, 0, 1, 0, 0, 3'd0, 1'b1), '0);
    put_run(ChHash, 7);
    put_row(ChNl, 1'b0, 1'b1, tok(KindHead, 1, 8, 8, 0, 3'd6, 1'b1), '0);
    put_run(ChStar, 3);
    put_run(ChNl, 1);
    put_run(ChTick, 3);
    put_run(ChNl, 1);
    put_run(ChTick, 2);
    put_row(ChTick, 1'b1, 1'b1, tok(KindCode, 17, 3, 0, 0, 3'd0, 1'b0),
            tok(KindEnd, 20, 0, 0, 0, 3'd0, 1'b1));
    put_row(ChSpace, 1'b1, 1'b1, tok(KindPara, 0, 1, 1, 0, 3'd0, 1'b0),
            tok(KindEnd, 1, 0, 0, 0, 3'd0, 1'b1));
    put_run(8'hFF, 1);
    put_row(8'h00, 1'b1, 1'b1, tok(KindPara, 0, 2, 0, 2, 3'd0, 1'b0),
            tok(KindEnd, 2, 0, 0, 0, 3'd0, 1'b1));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].t0, directed_rows[i].t1);

    run_docs(185);

    send_gap_pct = 49;
    run_docs(185);

    // sender waits for the block to empty completely
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_tokens.size() != 0);

    send_gap_pct = 0;
    stall_pct    = 49;
    hold_request = 300;
    run_docs(185);

    send_gap_pct = 6;
    stall_pct    = 6;
    run_docs(185);

    in_valid_i <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk_i);
      drain++;
    end while (pending_tokens.size() != 0 && drain < 10000);
    repeat (16) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      mismatches++;
      $display("%0t: %0d items expected but never seen", $time, pending_tokens.size());
    end
    if (mismatches == 0) $display("tb_markdown_block_line_classifier: PASS");
    else $display("tb_markdown_block_line_classifier: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mbc_pkg.sv
hw/rtl/mbc_core.sv
hw/rtl/mbc_outq.sv
hw/rtl/markdown_block_line_classifier.sv
tb/sv/tb_markdown_block_line_classifier.sv
